### src/amrd_pkg.sv
// Shared types, constants and model shape table of the range decoder.
`timescale 1ns / 1ps
`default_nettype none
package amrd_pkg;

    localparam int CODE_BITS         = 26;
    localparam int MAX_MODEL_SYMBOLS = 128;
    localparam int NUM_MODELS        = 9;
    localparam int FREQ_SLOTS        = 267;
    localparam int FREQ_W            = 11;
    localparam int ADDR_W            = 9;
    localparam int CNT_W             = 9;
    localparam int IDX_W             = 8;
    localparam int USED_W            = 6;

    localparam logic [CODE_BITS-1:0] CODER_ONE  = CODE_BITS'(1) << (CODE_BITS - 1);
    localparam logic [CODE_BITS-1:0] CODER_HALF = CODE_BITS'(1) << (CODE_BITS - 2);

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_DECODE = 2'd1;
    localparam logic [1:0] ACT_RESET  = 2'd2;

    localparam logic [3:0] MODEL_BINARY = 4'd0;
    localparam logic [3:0] MODEL_SELECT = 4'd1;
    localparam logic [3:0] MODEL_LAST   = 4'd8;

    typedef struct packed {
        logic [1:0]  action;
        logic [3:0]  model_select;
        logic [31:0] bit_window;
    } in_item_t;

    typedef struct packed {
        logic [7:0] symbol;
        logic [4:0] bits_used;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [FREQ_W-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic [7:0]        first;
        logic [CNT_W-1:0]  count;
        logic [3:0]        incr;
        logic [FREQ_W-1:0] limit;
        logic [ADDR_W-1:0] offset;
    } shape_t;

    function automatic shape_t model_shape(input logic [3:0] m);
        shape_t s;
        case (m)
            4'd0:    s = '{8'd0,   9'd2,   4'd1, 11'd256,  9'd0};
            4'd1:    s = '{8'd0,   9'd11,  4'd8, 11'd1024, 9'd2};
            4'd2:    s = '{8'd2,   9'd2,   4'd8, 11'd1024, 9'd13};
            4'd3:    s = '{8'd4,   9'd4,   4'd4, 11'd1024, 9'd15};
            4'd4:    s = '{8'd8,   9'd8,   4'd4, 11'd1024, 9'd19};
            4'd5:    s = '{8'd16,  9'd16,  4'd4, 11'd1024, 9'd27};
            4'd6:    s = '{8'd32,  9'd32,  4'd2, 11'd1024, 9'd43};
            4'd7:    s = '{8'd64,  9'd64,  4'd2, 11'd1024, 9'd75};
            default: s = '{8'd128, 9'd128, 4'd1, 11'd1024, 9'd139};
        endcase
        if (s.count > CNT_W'(MAX_MODEL_SYMBOLS)) begin
            s.count = CNT_W'(MAX_MODEL_SYMBOLS);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

### src/amrd_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module amrd_div
    import amrd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [31:0]          dividend,
    input  wire logic [CODE_BITS-1:0] divisor,
    output logic                      done,
    output logic [31:0]               quotient
);
    logic                 busy_reg;
    logic                 done_reg;
    logic [4:0]           cnt_reg;
    logic [31:0]          quo_reg;
    logic [CODE_BITS-1:0] rem_reg;
    logic [CODE_BITS-1:0] div_reg;
    logic [CODE_BITS:0]   trial;
    logic                 ge;

    assign trial = {rem_reg, quo_reg[31]};
    assign ge    = trial >= {1'b0, div_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                div_reg  <= divisor;
            end else if (busy_reg) begin
                quo_reg <= {quo_reg[30:0], ge};
                rem_reg <= ge ? CODE_BITS'(trial - {1'b0, div_reg}) : trial[CODE_BITS-1:0];
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

### src/amrd_freq_ram.sv
// Frequency table memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module amrd_freq_ram
    import amrd_pkg::*;
(
    input  wire logic              aclk,
    input  wire ram_wr_t           wr,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [FREQ_W-1:0]      rd_data
);
    logic [FREQ_W-1:0] mem [FREQ_SLOTS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

### src/adaptive_multi_model_range_decoder_unit.sv
// Top level of the adaptive multi-model range decoder.
//
// Input channel s_valid/s_ready/s_item carries an action (start, decode,
// reset block models), a model number and the next 32 stream bits, MSB
// first. Output channel m_valid/m_ready/m_item returns one item per input
// item: the decoded symbol and the number of stream bits consumed.
// One item is processed at a time; s_ready is high only while idle.
// Start and reset actions sweep the frequency memory. A decode runs the
// two serial divisions (one quotient bit per cycle), the cumulative
// search through the frequency memory port with a read and a compare
// per symbol, the renormalization shifts, and a halving pass when the
// model rescales.
// After reset the block runs a clearing pass over the frequency memory
// with s_ready low. A stalled receiver holds the result in the output
// register; the next item is taken meanwhile, and its result waits until
// the register frees up.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_multi_model_range_decoder_unit
    import amrd_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_item,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_item
);
    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_U_GO, S_U_WAIT, S_T_GO, S_T_WAIT,
        S_SRD, S_SCMP, S_MUL1, S_MUL2, S_NORM, S_BUMP, S_RS, S_OUT
    } state_t;

    state_t               state_reg;
    logic                 init_reg;
    logic [CODE_BITS-1:0] range_reg;
    logic [31:0]          code_reg;
    logic [FREQ_W-1:0]    totals_reg [NUM_MODELS];
    logic [3:0]           m_reg;
    logic [31:0]          win_reg;
    logic [CNT_W-1:0]     i_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [FREQ_W-1:0]    cum_reg;
    logic [FREQ_W-1:0]    size_reg;
    logic [FREQ_W-1:0]    tot_reg;
    logic [CODE_BITS-1:0] unit_reg;
    logic [31:0]          target_reg;
    logic [31:0]          low_reg;
    logic [FREQ_W:0]      sum_reg;
    logic [7:0]           sym_reg;
    logic [USED_W-1:0]    used_reg;
    logic                 m_valid_reg;
    out_item_t            m_item_reg;

    shape_t               shp;
    ram_wr_t              wr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [FREQ_W-1:0]    rd_data;
    logic                 div_start;
    logic [31:0]          div_dividend;
    logic [CODE_BITS-1:0] div_divisor;
    logic                 div_done;
    logic [31:0]          div_quo;
    logic [FREQ_W:0]      cum_f;
    logic [FREQ_W:0]      cum_size;
    logic [FREQ_W:0]      bump_tot;
    logic [FREQ_W:0]      half_f;
    logic [36:0]          prod;
    logic                 next_bit;

    assign shp      = model_shape(m_reg);
    assign cum_f    = {1'b0, cum_reg} + {1'b0, rd_data};
    assign cum_size = {1'b0, cum_reg} + {1'b0, size_reg};
    assign bump_tot = {1'b0, totals_reg[m_reg]} + (FREQ_W + 1)'(shp.incr);
    assign half_f   = ({1'b0, rd_data} + (FREQ_W + 1)'(1)) >> 1;
    assign prod     = (state_reg == S_MUL1) ? unit_reg * cum_reg : unit_reg * size_reg;
    assign next_bit = (used_reg < USED_W'(32)) ? win_reg[5'(31 - used_reg)] : 1'b0;

    // Divider: unit = range / total, then target = code / unit.
    assign div_start    = (state_reg == S_U_GO) || (state_reg == S_T_GO);
    assign div_dividend = (state_reg == S_U_GO) ? 32'(range_reg) : code_reg;
    assign div_divisor  = (state_reg == S_U_GO) ? CODE_BITS'(tot_reg) : unit_reg;

    amrd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Memory port steering: the states never overlap in their accesses.
    always_comb begin
        wr      = '0;
        rd_addr = shp.offset + ADDR_W'(idx_reg);
        case (state_reg)
            S_CLR: begin
                wr.en   = 1'b1;
                wr.addr = shp.offset + ADDR_W'(i_reg);
                wr.data = FREQ_W'(shp.incr);
            end
            S_BUMP: begin
                wr.en   = 1'b1;
                wr.addr = shp.offset + ADDR_W'(idx_reg);
                wr.data = size_reg + FREQ_W'(shp.incr);
            end
            S_RS: begin
                rd_addr = shp.offset + ADDR_W'(i_reg);
                wr.en   = (i_reg != '0);
                wr.addr = shp.offset + ADDR_W'(i_reg - CNT_W'(1));
                wr.data = half_f[FREQ_W-1:0];
            end
            default: begin
            end
        endcase
    end

    amrd_freq_ram u_ram (
        .aclk    (aclk),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            init_reg    <= 1'b1;
            m_reg       <= MODEL_BINARY;
            i_reg       <= '0;
            sym_reg     <= '0;
            used_reg    <= '0;
            range_reg   <= CODER_ONE;
            code_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // Drop the result once the receiver takes it, unless a new one loads now.
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        win_reg  <= s_item.bit_window;
                        sym_reg  <= '0;
                        used_reg <= '0;
                        i_reg    <= '0;
                        idx_reg  <= '0;
                        cum_reg  <= '0;
                        state_reg <= S_OUT;
                        if (s_item.action == ACT_START) begin
                            code_reg  <= 32'(s_item.bit_window >> (32 - CODE_BITS));
                            range_reg <= CODER_ONE;
                            used_reg  <= USED_W'(CODE_BITS);
                            m_reg     <= MODEL_BINARY;
                            state_reg <= S_CLR;
                        end else if (s_item.action == ACT_RESET) begin
                            m_reg     <= MODEL_SELECT;
                            state_reg <= S_CLR;
                        end else if (s_item.action == ACT_DECODE &&
                                     s_item.model_select <= MODEL_LAST) begin
                            m_reg     <= s_item.model_select;
                            tot_reg   <= (totals_reg[s_item.model_select] == '0) ?
                                         FREQ_W'(1) : totals_reg[s_item.model_select];
                            state_reg <= S_U_GO;
                        end
                    end
                end
                S_CLR: begin
                    // Restore one frequency per cycle, model after model.
                    if (i_reg == shp.count - CNT_W'(1)) begin
                        totals_reg[m_reg] <= FREQ_W'(shp.count * shp.incr);
                        i_reg <= '0;
                        if (m_reg == MODEL_LAST) begin
                            m_reg     <= MODEL_BINARY;
                            init_reg  <= 1'b0;
                            // The pass after reset answers no item.
                            state_reg <= init_reg ? S_IDLE : S_OUT;
                        end else begin
                            m_reg <= m_reg + 4'd1;
                        end
                    end else begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                S_U_GO:   state_reg <= S_U_WAIT;
                S_U_WAIT: begin
                    if (div_done) begin
                        unit_reg  <= (div_quo == '0) ? CODE_BITS'(1) : div_quo[CODE_BITS-1:0];
                        state_reg <= S_T_GO;
                    end
                end
                S_T_GO:   state_reg <= S_T_WAIT;
                S_T_WAIT: begin
                    if (div_done) begin
                        target_reg <= div_quo;
                        state_reg  <= S_SRD;
                    end
                end
                S_SRD: state_reg <= S_SCMP;
                S_SCMP: begin
                    // Stop at the last symbol or where the running sum passes target.
                    if ((CNT_W'(idx_reg) == shp.count - CNT_W'(1)) ||
                        (32'(cum_f) > target_reg)) begin
                        size_reg  <= rd_data;
                        state_reg <= S_MUL1;
                    end else begin
                        cum_reg   <= cum_f[FREQ_W-1:0];
                        idx_reg   <= idx_reg + IDX_W'(1);
                        state_reg <= S_SRD;
                    end
                end
                S_MUL1: begin
                    low_reg   <= prod[31:0];
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    code_reg <= code_reg - low_reg;
                    if (cum_size == {1'b0, tot_reg}) begin
                        range_reg <= CODE_BITS'(32'(range_reg) - low_reg);
                    end else begin
                        range_reg <= prod[CODE_BITS-1:0];
                    end
                    state_reg <= S_NORM;
                end
                S_NORM: begin
                    if (range_reg <= CODER_HALF && range_reg != '0) begin
                        range_reg <= range_reg << 1;
                        code_reg  <= {code_reg[30:0], next_bit};
                        used_reg  <= used_reg + USED_W'(1);
                    end else begin
                        state_reg <= S_BUMP;
                    end
                end
                S_BUMP: begin
                    sym_reg <= shp.first + idx_reg;
                    if (bump_tot > (FREQ_W + 1)'(shp.limit)) begin
                        i_reg     <= '0;
                        sum_reg   <= '0;
                        state_reg <= S_RS;
                    end else begin
                        totals_reg[m_reg] <= bump_tot[FREQ_W-1:0];
                        state_reg <= S_OUT;
                    end
                end
                S_RS: begin
                    // Halve: read entry i while writing back entry i-1.
                    if (i_reg != '0) begin
                        sum_reg <= sum_reg + half_f;
                    end
                    if (i_reg == shp.count) begin
                        totals_reg[m_reg] <= FREQ_W'(sum_reg + half_f);
                        state_reg <= S_OUT;
                    end else begin
                        i_reg <= i_reg + CNT_W'(1);
                    end
                end
                S_OUT: begin
                    // Hold until the output register is free.
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg          <= 1'b1;
                        m_item_reg.symbol    <= sym_reg;
                        m_item_reg.bits_used <= used_reg[4:0];
                        state_reg            <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### verif/amrd_scoreboard.sv
// Checker for the range decoder: predicts every result and compares it with the output.
`timescale 1ns / 1ps
module amrd_scoreboard
    import amrd_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_item_t  s_item,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_item_t m_item,
    output int        errors,
    output int        pending
);

    logic [31:0] dec_range;
    logic [31:0] dec_code;
    int          freq_ram [FREQ_SLOTS];
    int          model_total [NUM_MODELS];
    out_item_t   symbol_queue [$];

    // Per-model layout: first symbol, symbol count, increment, limit, table offset.
    task automatic model_layout(input int m, output int first, output int cnt,
                                output int incr, output int lim, output int offs);
        case (m)
            0: begin first = 0;   cnt = 2;   incr = 1; lim = 256;  offs = 0;   end
            1: begin first = 0;   cnt = 11;  incr = 8; lim = 1024; offs = 2;   end
            2: begin first = 2;   cnt = 2;   incr = 8; lim = 1024; offs = 13;  end
            3: begin first = 4;   cnt = 4;   incr = 4; lim = 1024; offs = 15;  end
            4: begin first = 8;   cnt = 8;   incr = 4; lim = 1024; offs = 19;  end
            5: begin first = 16;  cnt = 16;  incr = 4; lim = 1024; offs = 27;  end
            6: begin first = 32;  cnt = 32;  incr = 2; lim = 1024; offs = 43;  end
            7: begin first = 64;  cnt = 64;  incr = 2; lim = 1024; offs = 75;  end
            default: begin first = 128; cnt = 128; incr = 1; lim = 1024; offs = 139; end
        endcase
        if (cnt > MAX_MODEL_SYMBOLS) cnt = MAX_MODEL_SYMBOLS;
    endtask

    task automatic clear_model(input int m);
        int first, cnt, incr, lim, offs;
        model_layout(m, first, cnt, incr, lim, offs);
        for (int i = 0; i < cnt; i++) freq_ram[offs + i] = incr;
        model_total[m] = incr * cnt;
    endtask

    task automatic bump_symbol(input int m, input int idx);
        int first, cnt, incr, lim, offs, tot;
        model_layout(m, first, cnt, incr, lim, offs);
        freq_ram[offs + idx] = freq_ram[offs + idx] + incr;
        tot = model_total[m] + incr;
        if (tot > lim) begin
            tot = 0;
            for (int i = 0; i < cnt; i++) begin
                freq_ram[offs + i] = (freq_ram[offs + i] + 1) >> 1;
                tot += freq_ram[offs + i];
            end
        end
        model_total[m] = tot;
    endtask

    task automatic decode_item(input in_item_t it, output out_item_t res);
        int          first, cnt, incr, lim, offs, idx, used, m;
        logic [31:0] tot, unit, target, low, cum, size;
        res  = '0;
        used = 0;
        m    = int'(it.model_select);
        if (it.action == ACT_START) begin
            dec_code  = 32'(it.bit_window >> (32 - CODE_BITS));
            dec_range = 32'(CODER_ONE);
            for (int i = 0; i < NUM_MODELS; i++) clear_model(i);
            used = CODE_BITS;
        end else if (it.action == ACT_RESET) begin
            for (int i = 1; i < NUM_MODELS; i++) clear_model(i);
        end else if (it.action == ACT_DECODE && m < NUM_MODELS) begin
            model_layout(m, first, cnt, incr, lim, offs);
            tot = 32'(model_total[m]);
            if (tot == 0) tot = 1;
            unit = dec_range / tot;
            if (unit == 0) unit = 1;
            target = dec_code / unit;
            cum = 0;
            // The last symbol catches everything, including a corrupt code.
            for (idx = 0; idx + 1 < cnt; idx++) begin
                if (cum + 32'(freq_ram[offs + idx]) > target) break;
                cum += 32'(freq_ram[offs + idx]);
            end
            size = 32'(freq_ram[offs + idx]);
            low  = unit * cum;
            dec_code = dec_code - low;
            if (cum + size == tot) dec_range = dec_range - low;
            else dec_range = unit * size;
            while (dec_range <= 32'(CODER_HALF) && dec_range != 0) begin
                dec_range = dec_range << 1;
                dec_code  = (dec_code << 1) | ((used < 32) ? 32'(it.bit_window[31 - used]) : 0);
                used++;
            end
            bump_symbol(m, idx);
            res.symbol = 8'(first + idx);
        end
        res.bits_used = 5'(used);
    endtask

    assign pending = symbol_queue.size();

    always @(posedge aclk) begin
        out_item_t exp_item;
        if (!aresetn) begin
            dec_range = 32'(CODER_ONE);
            dec_code  = 0;
            for (int i = 0; i < NUM_MODELS; i++) clear_model(i);
            symbol_queue.delete();
            errors <= 0;
        end else begin
            if (s_valid && s_ready) begin
                decode_item(s_item, exp_item);
                symbol_queue.push_back(exp_item);
            end
            if (m_valid && m_ready) begin
                if (symbol_queue.size() == 0) begin
                    if (errors < 10) $display("unexpected result item: sym %0d bits %0d",
                                              m_item.symbol, m_item.bits_used);
                    errors <= errors + 1;
                end else begin
                    exp_item = symbol_queue.pop_front();
                    if (m_item.symbol !== exp_item.symbol ||
                        m_item.bits_used !== exp_item.bits_used) begin
                        if (errors < 10) $display("mismatch: sym exp %0d got %0d, bits exp %0d got %0d",
                                                  exp_item.symbol, m_item.symbol,
                                                  exp_item.bits_used, m_item.bits_used);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

### verif/tb_adaptive_multi_model_range_decoder_unit.sv
// Testbench top: drives stimulus into the range decoder and reports the verdict.
`timescale 1ns / 1ps
module tb_adaptive_multi_model_range_decoder_unit;
    import amrd_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int CYCLE_LIMIT  = 4000000;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_item;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_item;
    int        errors;
    int        pending;
    int        items_sent;
    int        cycle_count;

    adaptive_multi_model_range_decoder_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    amrd_scoreboard checker_inst (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .errors  (errors),
        .pending (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: stop a hung run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it; return on the accepting edge.
    task automatic offer_item(input logic [1:0] act, input logic [3:0] msel,
                              input logic [31:0] win);
        s_valid <= 1'b1;
        s_item  <= '{action: act, model_select: msel, bit_window: win};
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // Drop valid for a random gap between bursts.
    task automatic burst_gap(inout int burst_left);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 12);
        end
    endtask

    // Receiver: random stalls in phases, one long hold-off, stretches with no stalls.
    initial begin
        int phase_len;
        int stall_pct;
        bit held;
        m_ready = 1'b0;
        held    = 1'b0;
        @(posedge aclk);
        forever begin
            if (!held && items_sent >= 700) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (4000) @(posedge aclk);
            end
            phase_len = $urandom_range(20, 400);
            case ($urandom_range(0, 3))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                2:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            repeat (phase_len) begin
                m_ready <= ($urandom_range(0, 99) >= stall_pct);
                @(posedge aclk);
            end
        end
    end

    initial begin
        int burst_left;
        int counted;
        int pick;
        bit paused;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        items_sent  = 0;
        cycle_count = 0;
        burst_left  = 0;
        counted     = 0;
        paused      = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: decode before any start, extremes of the window, every model,
        // corrupt code (top window bit set), unknown action, out-of-range models.
        offer_item(ACT_DECODE, MODEL_BINARY, 32'h0);
        offer_item(ACT_START, 4'd0, 32'h0000_0000);
        offer_item(ACT_DECODE, MODEL_BINARY, 32'h0000_0000);
        for (int m = 0; m <= 8; m++) offer_item(ACT_DECODE, 4'(m), $urandom);
        offer_item(ACT_START, 4'd15, 32'hFFFF_FFFF);
        offer_item(ACT_DECODE, MODEL_LAST, 32'hFFFF_FFFF);
        offer_item(ACT_DECODE, MODEL_SELECT, 32'hFFFF_FFFF);
        offer_item(2'd3, 4'd5, $urandom);
        offer_item(ACT_DECODE, 4'd9, $urandom);
        offer_item(ACT_DECODE, 4'd15, $urandom);
        offer_item(ACT_RESET, 4'd3, $urandom);
        offer_item(ACT_START, 4'd0, $urandom >> 1);
        offer_item(ACT_DECODE, MODEL_LAST, $urandom);
        offer_item(ACT_RESET, 4'd0, $urandom);

        // Random: mostly decode runs inside a stream, with a little noise.
        while (counted < RANDOM_ITEMS) begin
            burst_gap(burst_left);
            if (!paused && counted >= 1200) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                // Let the checker log the last accepted item first.
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                offer_item(ACT_START, 4'($urandom), ($urandom_range(0, 3) == 0) ? $urandom
                                                                           : ($urandom >> 1));
                counted++;
            end else if (pick < 6) begin
                offer_item(ACT_RESET, 4'($urandom), $urandom);
                counted++;
            end else if (pick < 9) begin
                // Ignored items: unknown action or a model past the last one.
                if (pick == 6) offer_item(2'd3, 4'($urandom), $urandom);
                else offer_item(ACT_DECODE, 4'($urandom_range(9, 15)), $urandom);
            end else begin
                // Large class models are slow; keep them to a smaller share.
                offer_item(ACT_DECODE,
                           ($urandom_range(0, 4) == 0) ? 4'($urandom_range(6, 8))
                                                       : 4'($urandom_range(0, 5)),
                           $urandom);
                counted++;
            end
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (700) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### files.f
src/amrd_pkg.sv
src/amrd_div.sv
src/amrd_freq_ram.sv
src/adaptive_multi_model_range_decoder_unit.sv
verif/amrd_scoreboard.sv
verif/tb_adaptive_multi_model_range_decoder_unit.sv
